/* design/hfrp_pkg.sv */
// ----------------------------------------------------------------------------
// hfrp_pkg
// Shared constants and types for the H.264 FU-A RTP packetizer.
// ----------------------------------------------------------------------------
package hfrp_pkg;

	localparam int unsigned LENGTH_WIDTH_DEF = 16;

	localparam int unsigned MAXP_W = 12;
	localparam int unsigned TSTEP_W = 24;
	localparam int unsigned CFG_W = 24;
	localparam int unsigned TS_W = 32;
	localparam int unsigned ULEN_W = 16;

	// register map
	typedef enum logic [0:0] {
		REG_MAX_PAYLOAD    = 1'b0,
		REG_TIMESTAMP_STEP = 1'b1
	} reg_index_t;

	localparam logic [MAXP_W-1:0]  MAXP_RESET  = 12'd1400;
	localparam logic [TSTEP_W-1:0] TSTEP_RESET = 24'(90000 / 30);
	localparam logic [MAXP_W-1:0]  MAXP_FLOOR  = 12'd2;

	// FU-A header fields (RFC 6184)
	localparam logic [7:0] NRI_MASK   = 8'h60;
	localparam logic [7:0] TYPE_MASK  = 8'h1f;
	localparam logic [7:0] FU_A_TYPE  = 8'd28;
	localparam logic [7:0] FU_S_BIT   = 8'h80;
	localparam logic [7:0] FU_E_BIT   = 8'h40;

	// results one input byte can cause: indicator, header, body byte
	localparam int unsigned MAX_RES = 3;
	localparam int unsigned RCNT_W = 2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} result_t;

endpackage

/* design/h264_fua_rtp_packetizer.sv */
// ----------------------------------------------------------------------------
// h264_fua_rtp_packetizer
// Packs one NAL unit, one byte per transfer, into RTP payloads: single NAL
// unit packets up to max_payload, FU-A fragments beyond that.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  nal     | in        | nal_valid / nal_stall | data_byte, unit_start, unit_length
//  pkt     | out       | pkt_valid / pkt_stall | payload_byte, packet_end,
//          |           |                       | packet_timestamp
//  cfg     | in        | cfg_we                | cfg_index, cfg_data
//
//  - Each NAL byte goes through the state logic into a three-slot result
//    buffer; bytes run back to back while the pkt side keeps up.
//  - A byte that opens a fragment yields three results (indicator, header,
//    body byte), so the nal side stalls there while the result buffer
//    drains, at one transfer per cycle while pkt_stall is low.
//  - nal_stall is high while more than one result is pending, or one is
//    pending and pkt_stall holds it.
//  - arst_n clears the unit state, the timestamp, the buffer count and loads
//    the register reset values (max_payload 1400, timestamp_step 3000).
//
module h264_fua_rtp_packetizer #(
	parameter int unsigned LENGTH_WIDTH = hfrp_pkg::LENGTH_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_we,
	input  hfrp_pkg::reg_index_t        cfg_index,
	input  logic [hfrp_pkg::CFG_W-1:0]  cfg_data,

	input  logic                        nal_valid,
	output logic                        nal_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        unit_start,
	input  logic [hfrp_pkg::ULEN_W-1:0] unit_length,

	output logic                        pkt_valid,
	input  logic                        pkt_stall,
	output logic [7:0]                  payload_byte,
	output logic                        packet_end,
	output logic [hfrp_pkg::TS_W-1:0]   packet_timestamp
);
	import hfrp_pkg::*;

	localparam int unsigned LW = LENGTH_WIDTH;

	// configuration
	logic [MAXP_W-1:0]  max_payload_q;
	logic [TSTEP_W-1:0] timestamp_step_q;

	// unit state
	logic               fragmenting_q;
	logic [7:0]         unit_header_q;
	logic [LW-1:0]      bytes_left_q;
	logic [MAXP_W-1:0]  fragment_fill_q;
	logic               first_fragment_q;
	logic [TS_W-1:0]    timestamp_q;

	// result buffer; slot 0 is the one on the pkt port
	result_t            res_s1 [MAX_RES];
	logic [RCNT_W-1:0]  res_cnt_s1;
	logic [TS_W-1:0]    res_ts_s1;

	logic nal_xfer, pkt_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q    <= MAXP_RESET;
			timestamp_step_q <= TSTEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_PAYLOAD:    max_payload_q    <= cfg_data[MAXP_W-1:0];
				REG_TIMESTAMP_STEP: timestamp_step_q <= cfg_data[TSTEP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- next state
	logic [MAXP_W-1:0] mp;
	logic [LW-1:0]     mp_ext;
	logic [31:0]       len_wide;
	logic [LW-1:0]     len_in;
	logic [LW-1:0]     bl_dec;
	logic [MAXP_W-1:0] fill_inc;
	logic              frag_end;
	logic [7:0]        fu_hdr;

	logic              fragmenting_d;
	logic [7:0]        unit_header_d;
	logic [LW-1:0]     bytes_left_d;
	logic [MAXP_W-1:0] fragment_fill_d;
	logic              first_fragment_d;
	logic [TS_W-1:0]   timestamp_d;
	result_t           res_d [MAX_RES];
	logic [RCNT_W-1:0] res_cnt_d;

	always_comb begin
		mp       = (max_payload_q < MAXP_FLOOR) ? MAXP_FLOOR : max_payload_q;
		mp_ext   = LW'(mp);
		len_wide = 32'(unit_length);
		len_in   = len_wide[LW-1:0];
		if (len_in == '0)
			len_in = LW'(1);
		bl_dec   = bytes_left_q - LW'(1);
		fill_inc = fragment_fill_q + MAXP_W'(1);
		frag_end = (fill_inc >= mp) || (bl_dec == '0) ||
			(first_fragment_q && bl_dec == LW'(1));

		fu_hdr = unit_header_q & TYPE_MASK;
		if (first_fragment_q)
			fu_hdr = fu_hdr | FU_S_BIT;
		else if (bytes_left_q <= mp_ext)
			fu_hdr = fu_hdr | FU_E_BIT;

		fragmenting_d    = fragmenting_q;
		unit_header_d    = unit_header_q;
		bytes_left_d     = bytes_left_q;
		fragment_fill_d  = fragment_fill_q;
		first_fragment_d = first_fragment_q;
		timestamp_d      = timestamp_q;
		res_cnt_d        = '0;
		for (int i = 0; i < MAX_RES; i++)
			res_d[i] = '{data: data_byte, last: 1'b0};

		if (unit_start) begin
			bytes_left_d = len_in - LW'(1);
			if (len_in <= mp_ext) begin
				// fits: single NAL unit packet
				fragmenting_d = 1'b0;
				res_d[0]      = '{data: data_byte, last: (len_in == LW'(1))};
				res_cnt_d     = RCNT_W'(1);
			end else begin
				// header byte is held back for the FU indicator/header
				fragmenting_d    = 1'b1;
				unit_header_d    = data_byte;
				fragment_fill_d  = '0;
				first_fragment_d = 1'b1;
			end
		end else if (fragmenting_q) begin
			bytes_left_d    = bl_dec;
			fragment_fill_d = frag_end ? '0 : fill_inc;
			if (frag_end)
				first_fragment_d = 1'b0;
			if (bl_dec == '0) begin
				fragmenting_d = 1'b0;
				timestamp_d   = timestamp_q + TS_W'(timestamp_step_q);
			end
			if (fragment_fill_q == '0) begin
				res_d[0]  = '{data: (unit_header_q & NRI_MASK) | FU_A_TYPE, last: 1'b0};
				res_d[1]  = '{data: fu_hdr, last: 1'b0};
				res_d[2]  = '{data: data_byte, last: frag_end};
				res_cnt_d = RCNT_W'(3);
			end else begin
				res_d[0]  = '{data: data_byte, last: frag_end};
				res_cnt_d = RCNT_W'(1);
			end
		end else if (bytes_left_q != '0) begin
			bytes_left_d = bl_dec;
			res_d[0]     = '{data: data_byte, last: (bl_dec == '0)};
			res_cnt_d    = RCNT_W'(1);
		end
		// stray byte with no open unit: no result
	end

	// ---------------------------------------------------------------- handshake
	assign pkt_valid = (res_cnt_s1 != '0);
	assign pkt_xfer  = pkt_valid && !pkt_stall;
	assign nal_stall = !((res_cnt_s1 == '0) || (res_cnt_s1 == RCNT_W'(1) && pkt_xfer));
	assign nal_xfer  = nal_valid && !nal_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fragmenting_q    <= 1'b0;
			unit_header_q    <= '0;
			bytes_left_q     <= '0;
			fragment_fill_q  <= '0;
			first_fragment_q <= 1'b0;
			timestamp_q      <= '0;
		end else if (nal_xfer) begin
			fragmenting_q    <= fragmenting_d;
			unit_header_q    <= unit_header_d;
			bytes_left_q     <= bytes_left_d;
			fragment_fill_q  <= fragment_fill_d;
			first_fragment_q <= first_fragment_d;
			timestamp_q      <= timestamp_d;
		end
	end

	// result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_cnt_s1 <= '0;
		else if (nal_xfer)
			res_cnt_s1 <= res_cnt_d;
		else if (pkt_xfer)
			res_cnt_s1 <= res_cnt_s1 - RCNT_W'(1);
	end

	// result buffer payload; all results of one byte share its timestamp
	always_ff @(posedge clk) begin
		if (nal_xfer) begin
			res_s1    <= res_d;
			res_ts_s1 <= timestamp_q;
		end else if (pkt_xfer) begin
			for (int i = 0; i < MAX_RES - 1; i++)
				res_s1[i] <= res_s1[i+1];
		end
	end

	assign payload_byte     = res_s1[0].data;
	assign packet_end       = res_s1[0].last;
	assign packet_timestamp = res_ts_s1;

	// ---------------------------------------------------------------- checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_s1 <= RCNT_W'(MAX_RES))
		else $error("result count out of range");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		nal_stall |-> (res_cnt_s1 != '0))
		else $error("nal stalled with empty result buffer");

	a_frag_left: assert property (@(posedge clk) disable iff (!arst_n)
		fragmenting_q |-> (bytes_left_q != '0))
		else $error("fragmenting with no bytes left");

	a_ts_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(timestamp_q) |-> $past(nal_xfer))
		else $error("timestamp moved without a nal transfer");

endmodule
